// File: hw/rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache responder package
// Shared types, codes and constants for the ARP cache and responder.
// ----------------------------------------------------------------------------
package acr_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // item functions
   localparam logic [1:0] FUNC_PACKET = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_UPDATE = 2'd2;
   localparam logic [1:0] FUNC_TICK   = 2'd3;

   // ARP header constants
   localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
   localparam logic [15:0] PROTO_IPV4     = 16'h0800;
   localparam logic [7:0]  HW_LEN_MAC     = 8'h06;
   localparam logic [7:0]  PROTO_LEN_IPV4 = 8'h04;
   localparam logic [15:0] OP_REQUEST     = 16'd1;
   localparam logic [15:0] OP_REPLY       = 16'd2;

   localparam logic [15:0] MAX_AGE_RESET  = 16'd60000;
   localparam logic [15:0] AGE_SAT        = 16'hFFFF;

   // result status codes
   localparam logic [2:0] STATUS_REQ_HANDLED  = 3'd0;
   localparam logic [2:0] STATUS_REPLY_LEARNT = 3'd1;
   localparam logic [2:0] STATUS_UNKNOWN_OP   = 3'd2;
   localparam logic [2:0] STATUS_REJECTED     = 3'd3;
   localparam logic [2:0] STATUS_LOOKUP       = 3'd4;
   localparam logic [2:0] STATUS_UPDATED      = 3'd5;
   localparam logic [2:0] STATUS_TICK         = 3'd6;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_IP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_MAC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE   = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_len;
      logic [7:0]  proto_len;
      logic [15:0] opcode;
      logic [47:0] peer_mac;
      logic [31:0] peer_ip;
      logic [31:0] target_ip;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        send_reply;
      logic [47:0] reply_target_mac;
      logic [31:0] reply_target_ip;
      logic        mac_known;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic scan_clear;
      logic scan_step;
      logic write_entry;
      logic tick;
      logic load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] func;
      logic       pkt_ok;
      logic       op_request;
      logic       op_reply;
      logic       scan_hit;
      logic       scan_last;
   } dp_sts_type;

endpackage

// File: hw/rtl/acr_req_if.sv
// ----------------------------------------------------------------------------
// ARP request channel
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface acr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] hw_type;
   logic [15:0] proto_type;
   logic [7:0]  hw_len;
   logic [7:0]  proto_len;
   logic [15:0] opcode;
   logic [47:0] peer_mac;
   logic [31:0] peer_ip;
   logic [31:0] target_ip;

   modport source (
      output valid, func, hw_type, proto_type, hw_len, proto_len, opcode,
             peer_mac, peer_ip, target_ip,
      input  ready
   );
   modport sink (
      input  valid, func, hw_type, proto_type, hw_len, proto_len, opcode,
             peer_mac, peer_ip, target_ip,
      output ready
   );
endinterface

// File: hw/rtl/acr_rsp_if.sv
// ----------------------------------------------------------------------------
// ARP result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface acr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        send_reply;
   logic [47:0] reply_target_mac;
   logic [31:0] reply_target_ip;
   logic        mac_known;

   modport source (
      output valid, status, send_reply, reply_target_mac, reply_target_ip, mac_known,
      input  ready
   );
   modport sink (
      input  valid, status, send_reply, reply_target_mac, reply_target_ip, mac_known,
      output ready
   );
endinterface

// File: hw/rtl/acr_csr_if.sv
// ----------------------------------------------------------------------------
// ARP configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface acr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// File: hw/rtl/arp_cache_responder.sv
// ----------------------------------------------------------------------------
// ARP cache and responder
// Eight-entry IPv4-to-MAC cache with request validation and reply generation.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  - one item per transfer: received ARP packet, lookup, direct
//             update or tick, selected by func.
//   rsp_if  - exactly one result per item, in item order.
//   csr_if  - register writes (0 local IP, 1 local MAC, 2 max age); always
//             ready, write only while the block is idle.
// Timing:
//   An item is decoded the cycle after its transfer, then learning and lookup
//   scan the table one entry per cycle, learning then writes the chosen entry,
//   and the result register is loaded. Tick, rejected and unknown-op items
//   skip the scan. req_if.ready is high only when idle, so a new item is taken
//   only after the result of the last item has been loaded.
// Reset:
//   Registers return to 0, 0, 60000; every table entry becomes stale.
// Stall:
//   A pending result is held in the output register; the next item is still
//   taken and processed, and waits before its result load until rsp_if drains.
// ----------------------------------------------------------------------------
module arp_cache_responder (
   input  logic     clock,
   input  logic     reset,
   acr_req_if.sink  req_if,
   acr_rsp_if.source rsp_if,
   acr_csr_if.sink  csr_if
);
   import acr_pkg::*;

   dp_cmd_type   cmd;
   dp_sts_type   sts;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         req_ready;
   logic         rsp_valid;

   always_comb begin
      req_item.func       = req_if.func;
      req_item.hw_type    = req_if.hw_type;
      req_item.proto_type = req_if.proto_type;
      req_item.hw_len     = req_if.hw_len;
      req_item.proto_len  = req_if.proto_len;
      req_item.opcode     = req_if.opcode;
      req_item.peer_mac   = req_if.peer_mac;
      req_item.peer_ip    = req_if.peer_ip;
      req_item.target_ip  = req_if.target_ip;
   end

   assign req_if.ready            = req_ready;
   assign rsp_if.valid            = rsp_valid;
   assign rsp_if.status           = rsp_item.status;
   assign rsp_if.send_reply       = rsp_item.send_reply;
   assign rsp_if.reply_target_mac = rsp_item.reply_target_mac;
   assign rsp_if.reply_target_ip  = rsp_item.reply_target_ip;
   assign rsp_if.mac_known        = rsp_item.mac_known;
   assign csr_if.ready            = 1'b1;

   acr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   acr_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_item  (req_item),
      .csr_write (csr_if.valid),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .rsp_item  (rsp_item)
   );

endmodule

// File: hw/rtl/acr_dpath.sv
// ----------------------------------------------------------------------------
// ARP cache datapath
// Item register, binding table, scan pointer, replacement choice, result
// register and configuration registers.
// ----------------------------------------------------------------------------
module acr_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  acr_pkg::dp_cmd_type                 cmd,
   output acr_pkg::dp_sts_type                 sts,
   input  acr_pkg::req_item_type               req_item,
   input  logic                                csr_write,
   input  logic [acr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [acr_pkg::CSR_DATA_W-1:0]      csr_data,
   output acr_pkg::rsp_item_type               rsp_item
);
   import acr_pkg::*;

   req_item_type item_ff;

   logic [31:0] local_ip_ff;
   logic [47:0] local_mac_ff;
   logic [15:0] max_age_ff;

   logic [31:0] entry_ip_ff  [TABLE_ENTRIES];
   logic [47:0] entry_mac_ff [TABLE_ENTRIES];
   logic [15:0] entry_age_ff [TABLE_ENTRIES];

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic [15:0]      best_age_ff, best_age_in;
   logic             known_ff, known_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic [31:0] cur_ip;
   logic [15:0] cur_age;
   logic        cur_match;
   logic        cur_fresh;
   logic        learn_mode;
   logic        scan_hit;
   logic        scan_last;
   logic        pkt_ok;

   assign cur_ip     = entry_ip_ff[idx_ff];
   assign cur_age    = entry_age_ff[idx_ff];
   assign cur_match  = (cur_ip == item_ff.peer_ip);
   assign cur_fresh  = (cur_age < max_age_ff);
   assign learn_mode = (item_ff.func != FUNC_LOOKUP);
   // learning stops on a matching or stale entry, lookup on the first match
   assign scan_hit   = learn_mode ? (cur_match || !cur_fresh) : cur_match;
   assign scan_last  = (idx_ff == IDX_W'(TABLE_ENTRIES - 1));

   assign pkt_ok = (item_ff.hw_type == HW_TYPE_ETH) && (item_ff.proto_type == PROTO_IPV4) &&
                   (item_ff.hw_len == HW_LEN_MAC) && (item_ff.proto_len == PROTO_LEN_IPV4) &&
                   (item_ff.target_ip == local_ip_ff);

   always_comb begin
      sts.func       = item_ff.func;
      sts.pkt_ok     = pkt_ok;
      sts.op_request = (item_ff.opcode == OP_REQUEST);
      sts.op_reply   = (item_ff.opcode == OP_REPLY);
      sts.scan_hit   = scan_hit;
      sts.scan_last  = scan_last;
   end

   // scan pointer, replacement candidate and lookup flag
   always_comb begin
      idx_in      = idx_ff;
      pick_in     = pick_ff;
      best_age_in = best_age_ff;
      known_in    = known_ff;
      if (cmd.scan_clear) begin
         idx_in      = '0;
         pick_in     = '0;
         best_age_in = '0;
         known_in    = 1'b0;
      end else if (cmd.scan_step) begin
         if (!scan_last) begin
            idx_in = idx_ff + IDX_W'(1);
         end
         if (scan_hit) begin
            pick_in = idx_ff;
         end else if ((idx_ff == '0) || (best_age_ff < cur_age)) begin
            // oldest so far, lowest index wins a tie
            pick_in     = idx_ff;
            best_age_in = cur_age;
         end
         if (!learn_mode && cur_match) begin
            known_in = cur_fresh;
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in = '0;
         case (item_ff.func)
            FUNC_PACKET: begin
               if (!pkt_ok) begin
                  rsp_in.status = STATUS_REJECTED;
               end else if (item_ff.opcode == OP_REQUEST) begin
                  rsp_in.status           = STATUS_REQ_HANDLED;
                  rsp_in.send_reply       = 1'b1;
                  rsp_in.reply_target_mac = item_ff.peer_mac;
                  rsp_in.reply_target_ip  = item_ff.peer_ip;
               end else if (item_ff.opcode == OP_REPLY) begin
                  rsp_in.status = STATUS_REPLY_LEARNT;
               end else begin
                  rsp_in.status = STATUS_UNKNOWN_OP;
               end
            end
            FUNC_LOOKUP: begin
               rsp_in.status    = STATUS_LOOKUP;
               rsp_in.mac_known = known_ff;
            end
            FUNC_UPDATE: begin
               rsp_in.status = STATUS_UPDATED;
            end
            default: begin
               rsp_in.status = STATUS_TICK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pick_ff     <= pick_in;
      best_age_ff <= best_age_in;
      known_ff    <= known_in;
      rsp_ff      <= rsp_in;
      if (cmd.load_item) begin
         item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= '0;
         local_mac_ff <= '0;
         max_age_ff   <= MAX_AGE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOCAL_IP:  local_ip_ff  <= csr_data[31:0];
            CSR_LOCAL_MAC: local_mac_ff <= csr_data[47:0];
            CSR_MAX_AGE:   max_age_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // binding table; reset leaves every entry stale
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_ip_ff[i]  <= '0;
            entry_mac_ff[i] <= '0;
            entry_age_ff[i] <= AGE_SAT;
         end
      end else if (cmd.write_entry) begin
         entry_ip_ff[pick_ff]  <= item_ff.peer_ip;
         entry_mac_ff[pick_ff] <= item_ff.peer_mac;
         entry_age_ff[pick_ff] <= '0;
      end else if (cmd.tick) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (entry_age_ff[i] != AGE_SAT) begin
               entry_age_ff[i] <= entry_age_ff[i] + 16'd1;
            end
         end
      end
   end

   assign rsp_item = rsp_ff;

   // local MAC is held but not driven to any output; not part of the result
   logic unused_mac;
   assign unused_mac = ^local_mac_ff;
   logic unused_sink_ff;
   always_ff @(posedge clock) begin
      unused_sink_ff <= unused_mac & 1'b0;
   end

endmodule

// File: hw/rtl/acr_ctrl.sv
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences decode, table scan, table write and result hand-off per item.
// ----------------------------------------------------------------------------
module acr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  acr_pkg::dp_sts_type  sts,
   output acr_pkg::dp_cmd_type  cmd
);
   import acr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.func)
               FUNC_TICK: begin
                  cmd.tick = 1'b1;
                  state_in = ST_FINISH;
               end
               FUNC_LOOKUP, FUNC_UPDATE: begin
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SCAN;
               end
               default: begin
                  if (sts.pkt_ok && (sts.op_request || sts.op_reply)) begin
                     cmd.scan_clear = 1'b1;
                     state_in       = ST_SCAN;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit || sts.scan_last) begin
               state_in = (sts.func == FUNC_LOOKUP) ? ST_FINISH : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_entry = 1'b1;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the result register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// ARP cache responder testbench
// Drives packets, lookups, direct updates and ticks through the request
// channel, rewrites the registers between phases while the block is idle, and
// checks every result against an in-bench model of the cache.
// ----------------------------------------------------------------------------
module tb_top;
   import acr_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_PCT     = 38;
   localparam int DRAIN_CYCLES = 16;
   localparam int POOL_SIZE    = 12;
   localparam int PRINT_LIMIT  = 40;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;

   acr_req_if req_ch ();
   acr_rsp_if rsp_ch ();
   acr_csr_if csr_ch ();

   arp_cache_responder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // model copy of the registers and the table
   logic [31:0] node_ip;
   logic [47:0] node_mac;
   logic [15:0] age_limit;
   logic [31:0] cache_ip  [TABLE_ENTRIES];
   logic [47:0] cache_mac [TABLE_ENTRIES];
   logic [15:0] cache_age [TABLE_ENTRIES];

   rsp_item_type arp_expected [$];
   logic [31:0]  ip_pool [POOL_SIZE];
   int unsigned  err_count;
   int unsigned  rsp_seen;
   bit           steady;

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // cache model
   // ------------------------------------------------------------------------
   function automatic bit cache_fresh(int i);
      return cache_age[i] < age_limit;
   endfunction

   // first matching or stale entry wins, else the oldest, lowest index on ties
   function automatic void cache_learn(logic [31:0] ip, logic [47:0] mac);
      int pick;
      bit found;
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (!found) begin
            if (cache_ip[i] == ip || !cache_fresh(i)) begin
               pick  = i;
               found = 1'b1;
            end else if (cache_age[pick] < cache_age[i]) begin
               pick = i;
            end
         end
      end
      cache_ip[pick]  = ip;
      cache_mac[pick] = mac;
      cache_age[pick] = '0;
   endfunction

   function automatic rsp_item_type predict_arp_result(req_item_type it);
      rsp_item_type r;
      bit           hdr_ok;
      bit           hit;
      r   = '0;
      hit = 1'b0;
      case (it.func)
         FUNC_PACKET: begin
            hdr_ok = it.hw_type == HW_TYPE_ETH && it.proto_type == PROTO_IPV4 &&
                     it.hw_len == HW_LEN_MAC && it.proto_len == PROTO_LEN_IPV4 &&
                     it.target_ip == node_ip;
            if (!hdr_ok) begin
               r.status = STATUS_REJECTED;
            end else if (it.opcode == OP_REQUEST) begin
               cache_learn(it.peer_ip, it.peer_mac);
               r.status           = STATUS_REQ_HANDLED;
               r.send_reply       = 1'b1;
               r.reply_target_mac = it.peer_mac;
               r.reply_target_ip  = it.peer_ip;
            end else if (it.opcode == OP_REPLY) begin
               cache_learn(it.peer_ip, it.peer_mac);
               r.status = STATUS_REPLY_LEARNT;
            end else begin
               r.status = STATUS_UNKNOWN_OP;
            end
         end
         FUNC_LOOKUP: begin
            r.status = STATUS_LOOKUP;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!hit && cache_ip[i] == it.peer_ip) begin
                  hit         = 1'b1;
                  r.mac_known = cache_fresh(i);
               end
            end
         end
         FUNC_UPDATE: begin
            cache_learn(it.peer_ip, it.peer_mac);
            r.status = STATUS_UPDATED;
         end
         default: begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (cache_age[i] != AGE_SAT) cache_age[i] = cache_age[i] + 16'd1;
            r.status = STATUS_TICK;
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // item builders
   // ------------------------------------------------------------------------
   function automatic logic [47:0] rand48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0];
   endfunction

   function automatic logic [31:0] pool_ip();
      if ($urandom_range(99) < 90) return ip_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic req_item_type arp_packet(logic [15:0] op, logic [47:0] mac,
                                               logic [31:0] ip, logic [31:0] tgt);
      req_item_type it;
      it.func       = FUNC_PACKET;
      it.hw_type    = HW_TYPE_ETH;
      it.proto_type = PROTO_IPV4;
      it.hw_len     = HW_LEN_MAC;
      it.proto_len  = PROTO_LEN_IPV4;
      it.opcode     = op;
      it.peer_mac   = mac;
      it.peer_ip    = ip;
      it.target_ip  = tgt;
      return it;
   endfunction

   // non-packet item; the header fields carry junk the block must ignore
   function automatic req_item_type table_item(logic [1:0] fn, logic [31:0] ip,
                                               logic [47:0] mac);
      req_item_type it;
      it.func       = fn;
      it.hw_type    = 16'($urandom);
      it.proto_type = 16'($urandom);
      it.hw_len     = 8'($urandom);
      it.proto_len  = 8'($urandom);
      it.opcode     = 16'($urandom);
      it.peer_mac   = mac;
      it.peer_ip    = ip;
      it.target_ip  = $urandom;
      return it;
   endfunction

   function automatic req_item_type gen_traffic_item();
      req_item_type it;
      int           pick;
      logic [15:0]  op;
      pick = $urandom_range(99);
      if (pick < 20) return table_item(FUNC_LOOKUP, pool_ip(), rand48());
      if (pick < 33) return table_item(FUNC_UPDATE, pool_ip(), rand48());
      if (pick < 50) return table_item(FUNC_TICK, $urandom, rand48());
      pick = $urandom_range(99);
      if (pick < 45)      op = OP_REQUEST;
      else if (pick < 85) op = OP_REPLY;
      else                op = 16'($urandom);
      it = arp_packet(op, rand48(), pool_ip(), node_ip);
      // broken headers: each field wrong on its own or several at once
      if ($urandom_range(99) < 20) begin
         if ($urandom_range(1)) it.hw_type    = 16'($urandom);
         if ($urandom_range(1)) it.proto_type = 16'($urandom);
         if ($urandom_range(1)) it.hw_len     = 8'($urandom);
         if ($urandom_range(1)) it.proto_len  = 8'($urandom);
         if ($urandom_range(1)) it.target_ip  = $urandom;
      end
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // channel tasks; all are entered and left at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_arp_item(req_item_type it);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= it.func;
      req_ch.hw_type    <= it.hw_type;
      req_ch.proto_type <= it.proto_type;
      req_ch.hw_len     <= it.hw_len;
      req_ch.proto_len  <= it.proto_len;
      req_ch.opcode     <= it.opcode;
      req_ch.peer_mac   <= it.peer_mac;
      req_ch.peer_ip    <= it.peer_ip;
      req_ch.target_ip  <= it.target_ip;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      arp_expected.push_back(predict_arp_result(it));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (arp_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         CSR_LOCAL_IP:  node_ip   = data[31:0];
         CSR_LOCAL_MAC: node_mac  = data;
         CSR_MAX_AGE:   age_limit = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // upper data bits are junk the block must drop
   task automatic configure(logic [31:0] ip, logic [47:0] mac, logic [15:0] age);
      logic [47:0] junk;
      junk = rand48();
      wait_drained();
      write_csr(CSR_LOCAL_IP, {junk[15:0], ip});
      write_csr(CSR_LOCAL_MAC, mac);
      write_csr(CSR_MAX_AGE, {junk[47:16], age});
   endtask

   task automatic random_phase(int n, bit no_idle, bit pause_midway);
      steady = no_idle;
      for (int k = 0; k < n; k++) begin
         if (pause_midway && k == n / 2) wait_drained();
         send_arp_item(gen_traffic_item());
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_state();
      // entries come out of reset stale, so even IP 0 is unknown
      send_arp_item(table_item(FUNC_LOOKUP, 32'h0, rand48()));
      send_arp_item(table_item(FUNC_TICK, $urandom, rand48()));
      send_arp_item(table_item(FUNC_LOOKUP, 32'h0, rand48()));
   endtask

   task automatic test_header_checks();
      configure('1, '1, MAX_AGE_RESET);
      send_arp_item(arp_packet(OP_REQUEST, rand48(), ip_pool[0], node_ip));
      send_arp_item(arp_packet(OP_REPLY, rand48(), ip_pool[1], node_ip));
      send_arp_item(arp_packet(16'h0000, rand48(), ip_pool[2], node_ip));
      send_arp_item(arp_packet(16'hFFFF, rand48(), ip_pool[2], node_ip));
      begin
         req_item_type it;
         it = arp_packet(OP_REQUEST, rand48(), ip_pool[3], node_ip);
         it.hw_type = 16'hFFFF;
         send_arp_item(it);
         it = arp_packet(OP_REPLY, rand48(), ip_pool[3], node_ip);
         it.proto_type = 16'h0000;
         send_arp_item(it);
         it = arp_packet(OP_REQUEST, rand48(), ip_pool[3], node_ip);
         it.hw_len = 8'hFF;
         send_arp_item(it);
         it = arp_packet(OP_REQUEST, rand48(), ip_pool[3], node_ip);
         it.proto_len = 8'h00;
         send_arp_item(it);
      end
      send_arp_item(arp_packet(OP_REQUEST, rand48(), ip_pool[3], 32'h0));
      send_arp_item(arp_packet(OP_REQUEST, 48'h0, 32'hFFFF_FFFF, node_ip));
      send_arp_item(table_item(FUNC_LOOKUP, ip_pool[0], rand48()));
      send_arp_item(table_item(FUNC_LOOKUP, ip_pool[3], rand48()));
   endtask

   task automatic test_local_ip_zero();
      configure(32'h0, 48'h0, MAX_AGE_RESET);
      send_arp_item(arp_packet(OP_REQUEST, '1, 32'h0, 32'h0));
      send_arp_item(table_item(FUNC_LOOKUP, 32'h0, rand48()));
   endtask

   task automatic test_ageing();
      logic [31:0] ip_a;
      ip_a = $urandom;
      configure($urandom, rand48(), 16'd1);
      write_csr(CSR_UNUSED, rand48());
      send_arp_item(table_item(FUNC_UPDATE, ip_a, rand48()));
      send_arp_item(table_item(FUNC_LOOKUP, ip_a, rand48()));
      send_arp_item(table_item(FUNC_TICK, $urandom, rand48()));
      send_arp_item(table_item(FUNC_LOOKUP, ip_a, rand48()));
      // a zero limit makes every entry stale
      configure(node_ip, node_mac, 16'd0);
      send_arp_item(table_item(FUNC_UPDATE, ip_a, rand48()));
      send_arp_item(table_item(FUNC_LOOKUP, ip_a, rand48()));
   endtask

   task automatic test_replacement();
      configure(node_ip, node_mac, AGE_SAT);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         send_arp_item(table_item(FUNC_UPDATE, 32'h0A00_0001 + 32'(i), rand48()));
      send_arp_item(table_item(FUNC_TICK, $urandom, rand48()));
      // table full and fresh: the oldest goes
      send_arp_item(table_item(FUNC_UPDATE, 32'h0A00_00FF, rand48()));
      send_arp_item(table_item(FUNC_LOOKUP, 32'h0A00_0001, rand48()));
   endtask

   task automatic test_random_long_age();
      configure($urandom, rand48(), 16'($urandom_range(1, 65534)));
      random_phase(350, 1'b0, 1'b0);
   endtask

   task automatic test_random_short_age();
      configure(ip_pool[$urandom_range(POOL_SIZE - 1)], rand48(),
                16'($urandom_range(2, 12)));
      random_phase(350, 1'b0, 1'b0);
   endtask

   task automatic test_random_no_idle();
      configure($urandom, rand48(), MAX_AGE_RESET);
      random_phase(300, 1'b1, 1'b0);
   endtask

   task automatic test_random_pressure();
      configure($urandom, rand48(), 16'($urandom_range(1, 6)));
      random_phase(400, 1'b0, 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (err_count < PRINT_LIMIT)
         $display("result %0d: %s got %0h expected %0h", rsp_seen, what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (arp_expected.size() == 0) begin
            report_mismatch("unexpected transfer, status", 64'(rsp_ch.status), '0);
         end else begin
            want = arp_expected.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
            if (rsp_ch.send_reply !== want.send_reply)
               report_mismatch("send_reply", 64'(rsp_ch.send_reply),
                               64'(want.send_reply));
            if (rsp_ch.reply_target_mac !== want.reply_target_mac)
               report_mismatch("reply_target_mac", 64'(rsp_ch.reply_target_mac),
                               64'(want.reply_target_mac));
            if (rsp_ch.reply_target_ip !== want.reply_target_ip)
               report_mismatch("reply_target_ip", 64'(rsp_ch.reply_target_ip),
                               64'(want.reply_target_ip));
            if (rsp_ch.mac_known !== want.mac_known)
               report_mismatch("mac_known", 64'(rsp_ch.mac_known),
                               64'(want.mac_known));
         end
         rsp_seen++;
      end
   end

   // result back-pressure
   always @(negedge clock)
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_TICK;
      req_ch.hw_type    = '0;
      req_ch.proto_type = '0;
      req_ch.hw_len     = '0;
      req_ch.proto_len  = '0;
      req_ch.opcode     = '0;
      req_ch.peer_mac   = '0;
      req_ch.peer_ip    = '0;
      req_ch.target_ip  = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_LOCAL_IP;
      csr_ch.data       = '0;

      node_ip   = '0;
      node_mac  = '0;
      age_limit = MAX_AGE_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         cache_ip[i]  = '0;
         cache_mac[i] = '0;
         cache_age[i] = AGE_SAT;
      end
      ip_pool[0] = 32'h0;
      ip_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_header_checks();
      test_local_ip_zero();
      test_ageing();
      test_replacement();
      test_random_long_age();
      test_random_short_age();
      test_random_no_idle();
      test_random_pressure();

      wait_drained();
      if (err_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #(2 * HALF_PERIOD * 2000000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
